// ===== rtl/sps_pkg.sv =====
// Shared types, constants and register indexes for the short-pattern search core.
package sps_pkg;

  localparam int unsigned     DEF_PATTERN_BYTES   = 16;
  localparam longint unsigned DEF_MAX_TEXT_LENGTH = 64'd65535;

  localparam int unsigned TEXT_W      = 8;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned PAT_W       = 2 * CFG_DATA_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } res_t;

endpackage

// ===== rtl/sps_in_reg.sv =====
// Input register stage: holds one accepted text byte until the matcher takes it.
module sps_in_reg
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TEXT_W-1:0] in_byte,
  input  logic              take,
  output logic              s1_valid,
  output logic [TEXT_W-1:0] s1_byte
);

  logic              valid_r, valid_nxt;
  logic [TEXT_W-1:0] byte_r;
  logic              accept;

  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// ===== rtl/sps_matcher.sv =====
// Window compare, string position and match state; decides the result per byte.
module sps_matcher
  import sps_pkg::*;
#(
  parameter int unsigned     PATTERN_BYTES   = DEF_PATTERN_BYTES,
  parameter longint unsigned MAX_TEXT_LENGTH = DEF_MAX_TEXT_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  logic [TEXT_W-1:0]     s1_byte,
  input  logic                  out_free,
  input  logic [CFG_DATA_W-1:0] pattern_low,
  input  logic [CFG_DATA_W-1:0] pattern_high,
  input  logic [LEN_W-1:0]      pattern_length,
  output logic                  take,
  output logic                  load,
  output res_t                  res
);

  localparam int unsigned WIN = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
  localparam logic [OFFSET_W-1:0] CountLimit =
    (MAX_TEXT_LENGTH > 64'd65535) ? 16'hFFFF : 16'(MAX_TEXT_LENGTH);
  localparam logic [LEN_W-1:0] LenCap = LEN_W'(PATTERN_BYTES);

  logic [TEXT_W-1:0]   window_r [WIN];
  logic [OFFSET_W-1:0] count_r, count_nxt;
  logic                reported_r, reported_nxt;

  logic [PAT_W-1:0]    pat;
  logic [TEXT_W-1:0]   win_bytes [PATTERN_BYTES];
  logic [LEN_W-1:0]    len_eff;
  logic                win_match;
  logic [OFFSET_W:0]   seen;
  logic                hit;
  logic                is_term;
  logic                want;

  assign pat     = {pattern_high, pattern_low};
  assign len_eff = (pattern_length > LenCap) ? LenCap : pattern_length;
  assign is_term = (s1_byte == '0);
  assign seen    = {1'b0, count_r} + 17'd1;

  // newest byte at slot 0, older bytes behind it
  always_comb begin
    win_bytes[0] = s1_byte;
    for (int k = 1; k < PATTERN_BYTES; k++) begin
      win_bytes[k] = window_r[k-1];
    end
  end

  // one compare set per possible length; the configured length picks one
  always_comb begin
    logic m;
    win_match = 1'b0;
    for (int l = 1; l <= PATTERN_BYTES; l++) begin
      m = 1'b1;
      for (int i = 0; i < l; i++) begin
        m = m && (win_bytes[l-1-i] == pat[8*i +: 8]);
      end
      if (len_eff == LEN_W'(l)) begin
        win_match = m;
      end
    end
  end

  always_comb begin
    if (len_eff == '0) begin
      hit = 1'b1;
    end else begin
      hit = !is_term && (seen >= 17'(len_eff)) && win_match;
    end
  end

  assign want = !reported_r && (hit || is_term);
  assign take = s1_valid && (!want || out_free);
  assign load = take && want;

  // empty pattern always reports offset 0
  assign res.found        = hit;
  assign res.match_offset = (hit && (len_eff != '0)) ? OFFSET_W'(seen - 17'(len_eff)) : '0;

  always_comb begin
    count_nxt    = count_r;
    reported_nxt = reported_r;
    if (take) begin
      if (is_term) begin
        count_nxt    = '0;
        reported_nxt = 1'b0;
      end else begin
        if (count_r < CountLimit) begin
          count_nxt = count_r + 16'd1;
        end
        reported_nxt = reported_r || (want && hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      reported_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      reported_r <= reported_nxt;
    end
  end

  // history only read where the position count proves it belongs to this string
  always_ff @(posedge clk) begin
    if (take && !is_term) begin
      window_r[0] <= s1_byte;
      for (int k = 1; k < WIN; k++) begin
        window_r[k] <= window_r[k-1];
      end
    end
  end

endmodule

// ===== rtl/sps_out_reg.sv =====
// Result register: holds one result transaction until the receiver takes it.
module sps_out_reg
  import sps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_t                   res_in,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_free
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'b0, res_r.match_offset, res_r.found};

endmodule

// ===== rtl/short_pattern_substring_search_core.sv =====
// Top level of the short-pattern substring search core.
//
// Usage:
//   Load the pattern through the cfg_ port (index 0: bytes 0..7, index 1:
//   bytes 8..15, index 2: length 0..16) while no string is in flight.
//   Stream a zero-terminated string one byte per in_ transaction. For each
//   string exactly one result transaction comes out on out_: found=1 with the
//   start offset of the first occurrence as soon as the match completes, or
//   found=0 at the terminator. Bytes after a match are consumed silently.
//   An empty pattern reports found at offset 0 on the first byte.
// Result path: a byte that completes a match or ends the string passes the input
//   register, then the result register, which raises out_tvalid.
// Throughput: one byte per cycle while no byte is held back (see Stall); the 16-byte
//   window compare sits between the input register and the result register.
// Reset: clears the pattern, position count and match flag; no result pending.
// Stall: while a result waits on out_tready, bytes that produce no result keep
//   flowing; a byte that would produce one holds in the input register and
//   in_tready drops once that register is occupied.
module short_pattern_substring_search_core
  import sps_pkg::*;
#(
  parameter int unsigned     PATTERN_BYTES   = DEF_PATTERN_BYTES,
  parameter longint unsigned MAX_TEXT_LENGTH = DEF_MAX_TEXT_LENGTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TEXT_W-1:0]      in_tdata,   // [7:0] text_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] found, [16:1] match_offset, [23:17] zero
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_low_r, pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        CFG_PAT_HIGH: pat_high_r <= cfg_wdata;
        CFG_PAT_LEN:  pat_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;    // unused index, write dropped
      endcase
    end
  end

  logic              s1_valid;
  logic [TEXT_W-1:0] s1_byte;
  logic              take;
  logic              load;
  logic              out_free;
  res_t              res;

  sps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_byte  (in_tdata),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  sps_matcher #(
    .PATTERN_BYTES  (PATTERN_BYTES),
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
  ) u_matcher (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .s1_byte       (s1_byte),
    .out_free      (out_free),
    .pattern_low   (pat_low_r),
    .pattern_high  (pat_high_r),
    .pattern_length(pat_len_r),
    .take          (take),
    .load          (load),
    .res           (res)
  );

  sps_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_free  (out_free)
  );

  // a miss never carries an offset
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[16:1] == '0))
    else $error("not-found result with nonzero offset");

  // a new result only lands in a free result register
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result register overwritten");

  // input back-pressure only while a byte is parked
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && !take))
    else $error("input stalled with empty stage");

  // a parked byte that was not taken stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !take) |=> (s1_valid && $stable(s1_byte)))
    else $error("parked byte lost");

endmodule

// ===== sim/tb.sv =====
// Testbench for short_pattern_substring_search_core: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
  import sps_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int unsigned PHASE_ITEMS   = 148;   // at least this many bytes per random phase
  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 8;     // two-stage pipe plus margin
  localparam int unsigned QUIET_LIMIT   = 3000;  // cycles without any transaction
  localparam int unsigned MAX_PRINTS    = 40;

  // Behavior limits, worked out from the defaults the core is built with
  localparam int unsigned PAT_CAP   = (DEF_PATTERN_BYTES > 16) ? 16 : DEF_PATTERN_BYTES;
  localparam int unsigned POS_LIMIT =
    (DEF_MAX_TEXT_LENGTH > 64'd65535) ? 65535 : int'(DEF_MAX_TEXT_LENGTH);

  // Index 3 has no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Result field positions inside out_tdata
  localparam int unsigned OFS_LSB = 1;
  localparam int unsigned PAD_LSB = OFS_LSB + OFFSET_W;

  // ---------------------------------------------------------------------------
  // DUT signals; the ones the bench drives are known from time zero
  // ---------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [TEXT_W-1:0]      in_tdata   = '0;   // [7:0] text_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [0] found, [16:1] match_offset, [23:17] zero
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  short_pattern_substring_search_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Search predictor state: pattern copy plus per-string window, count and flag
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0] pat_bytes = '0;        // byte i in bits 8i+7..8i
  logic [LEN_W-1:0] pat_len   = '0;
  logic [7:0]       recent_q [15];          // index 0 = most recent byte
  int unsigned      pos_cnt   = 0;
  bit               hit_done  = 1'b0;       // string already produced its result

  res_t        search_outcomes [$];         // outcomes still owed by the core
  int unsigned err_count   = 0;
  int unsigned quiet_cycles = 0;

  // Pacing controls for the sender and the receiver process
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  logic [7:0] text_alphabet [3];

  // Directed stimulus table
  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;      // text byte in [7:0] for ROW_BYTE
    bit                    typed;    // outcome written in the row
    bit                    t_found;
    logic [OFFSET_W-1:0]   t_off;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  dir_row_t directed_rows [DIR_ROWS];

  initial begin
    foreach (recent_q[k]) recent_q[k] = '0;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // Mostly short gaps, a few long ones; zero when idling is switched off
  function automatic int unsigned pick_gap(input bit idle_on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return text_alphabet[$urandom_range(0, 2)];
    if (r < 97) return 8'($urandom_range(1, 255));
    return 8'h00;   // early terminator: breaks the string in two
  endfunction

  // One text byte through the search: updates the window and reports an outcome if one is owed
  task automatic predict_search(input logic [7:0] b, output bit has_res, output res_t r);
    int unsigned len, seen, off, k;
    bit          hit;
    logic [7:0]  wb;
    len     = (pat_len > PAT_CAP) ? PAT_CAP : pat_len;
    seen    = pos_cnt + 1;
    has_res = 1'b0;
    r       = '0;
    if (!hit_done) begin
      hit = 1'b0;
      off = 0;
      if (len == 0) begin
        hit = 1'b1;           // empty pattern hits on the first byte, even a terminator
      end else if (b != 8'h00 && seen >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          k  = len - 1 - i;
          wb = (k == 0) ? b : recent_q[k-1];
          if (wb != pat_bytes[i*8 +: 8]) hit = 1'b0;
        end
        off = seen - len;     // uses the saturated count past the limit
      end
      if (hit) begin
        has_res        = 1'b1;
        r.found        = 1'b1;
        r.match_offset = off[OFFSET_W-1:0];
        hit_done       = 1'b1;
      end else if (b == 8'h00) begin
        has_res = 1'b1;       // terminator without a match: not found, offset 0
      end
    end
    if (b == 8'h00) begin
      foreach (recent_q[j]) recent_q[j] = '0;
      pos_cnt  = 0;
      hit_done = 1'b0;
    end else begin
      for (int j = 14; j > 0; j--) recent_q[j] = recent_q[j-1];
      recent_q[0] = b;
      if (pos_cnt < POS_LIMIT) pos_cnt++;
    end
  endtask

  // Offer one byte; valid stays high across back-to-back transactions
  task automatic push_byte(input logic [7:0] b, input bit typed, input bit t_found,
                           input logic [OFFSET_W-1:0] t_off);
    int unsigned gap;
    bit          has_res;
    res_t        r;
    gap = pick_gap(tx_idle_on);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_search(b, has_res, r);
    if (typed) begin
      has_res        = 1'b1;
      r.found        = t_found;
      r.match_offset = t_off;
    end
    if (has_res) search_outcomes.push_back(r);
  endtask

  // Stop offering, wait out every owed outcome, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (search_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PAT_LOW:  pat_bytes[CFG_DATA_W-1:0]     = val;
      CFG_PAT_HIGH: pat_bytes[PAT_W-1:CFG_DATA_W] = val;
      CFG_PAT_LEN:  pat_len                       = val[LEN_W-1:0];
      default: ;    // spare index: no register
    endcase
  endtask

  // One random phase: new pattern setting, then well-formed strings with noise
  task automatic run_phase(input int p);
    logic [PAT_W-1:0]      pat_word;
    logic [CFG_DATA_W-1:0] len_val;
    logic [7:0]            str_q [$];
    int unsigned           len_wr, eff, slen, pos, sent;
    for (int i = 0; i < 3; i++) text_alphabet[i] = 8'($urandom_range(1, 255));
    pat_word = {$urandom, $urandom, $urandom, $urandom};   // bytes above length stay junk
    len_wr   = $urandom_range(1, 16);
    case (p)
      0: len_wr = 0;                                          // empty pattern
      1: begin                                                // all-ones, full length
        text_alphabet[0] = 8'hFF;
        text_alphabet[1] = 8'hFF;
        len_wr           = 16;
      end
      2: len_wr = 31;                                         // overlong, clamps
      3: len_wr = 17;
      4: len_wr = $urandom_range(2, 16);                      // all-zero pattern
      5: len_wr = 1;
      default: ;
    endcase
    eff = (len_wr > PAT_CAP) ? PAT_CAP : len_wr;
    for (int i = 0; i < eff; i++) pat_word[i*8 +: 8] = text_alphabet[$urandom_range(0, 2)];
    if (p == 1) pat_word = '1;
    if (p == 4) pat_word = '0;
    // occasional zero byte inside the pattern: can never match
    if (p > 5 && eff > 1 && $urandom_range(0, 7) == 0)
      pat_word[$urandom_range(0, eff - 1)*8 +: 8] = 8'h00;

    if (p == 2) len_val = '1;                                 // all ones reads as 31
    else if (p % 2 == 1) len_val = {$urandom, $urandom};      // junk above the length bits
    else len_val = '0;
    len_val[LEN_W-1:0] = len_wr[LEN_W-1:0];

    settle();
    write_reg(CFG_PAT_LOW,  pat_word[CFG_DATA_W-1:0]);
    write_reg(CFG_PAT_HIGH, pat_word[PAT_W-1:CFG_DATA_W]);
    write_reg(CFG_PAT_LEN,  len_val);
    if (p == 6) write_reg(CFG_SPARE, {$urandom, $urandom});

    // stretches with no idling on one side or both
    tx_idle_on = !(p == 4 || p == 9);
    rx_idle_on = !(p == 3 || p == 9);
    if (p == 2 || p == 7) hold_req = 1'b1;

    sent = 0;
    while (sent < PHASE_ITEMS) begin
      str_q.delete();
      slen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60)
                                          : $urandom_range(0, 2*eff + 6);
      for (int i = 0; i < slen; i++) str_q.push_back(pick_text_byte());
      if (eff > 0 && slen >= eff && $urandom_range(0, 9) < 6) begin
        pos = $urandom_range(0, slen - eff);
        for (int i = 0; i < eff; i++) str_q[pos + i] = pat_word[i*8 +: 8];
      end
      str_q.push_back(8'h00);
      foreach (str_q[i]) push_byte(str_q[i], 1'b0, 1'b0, '0);
      sent += str_q.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready with stalls, plus the long hold-off on request.
  // During the hold the sender keeps going, so the core backs up to in_tready.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    bit          ready_val;
    int unsigned dur;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        ready_val = 1'b0;
        dur       = HOLD_CYCLES;
      end else if (!rx_idle_on) begin
        ready_val = 1'b1;
        dur       = 16;
      end else if ($urandom_range(0, 99) < 65) begin
        ready_val = 1'b1;
        dur       = $urandom_range(1, 8);
      end else begin
        ready_val = 1'b0;
        dur       = pick_gap(1'b1) + 1;
      end
      out_tready <= ready_val;
      repeat (dur) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each result transaction against the oldest owed outcome
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (search_outcomes.size() == 0) begin
        report_mismatch("result with nothing owed, tdata", 32'(out_tdata), 32'd0);
      end else begin
        want = search_outcomes.pop_front();
        if (out_tdata[0] !== want.found)
          report_mismatch("found", 32'(out_tdata[0]), 32'(want.found));
        if (out_tdata[OFS_LSB +: OFFSET_W] !== want.match_offset)
          report_mismatch("match_offset", 32'(out_tdata[OFS_LSB +: OFFSET_W]),
                          32'(want.match_offset));
        if (out_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
          report_mismatch("pad bits", 32'(out_tdata[OUT_TDATA_W-1:PAD_LSB]), 32'd0);
      end
    end
  end

  // Watchdog: too long with no transaction on any port means a hang
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    // kind, index, value, typed, found, offset
    directed_rows = '{
      // reset leaves an empty pattern: first byte of every string hits at 0
      '{ROW_BYTE, CFG_PAT_LOW,  64'h41,                 1'b1, 1'b1, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'hFF,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b0, 1'b0, 16'd0},
      // terminator as the first byte still hits on the empty pattern
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b1, 1'b1, 16'd0},
      // two-byte pattern 01 FF, all-ones junk in the upper register
      '{ROW_CFG,  CFG_PAT_LOW,  64'h0000_0000_0000_FF01, 1'b0, 1'b0, 16'd0},
      '{ROW_CFG,  CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 16'd0},
      '{ROW_CFG,  CFG_PAT_LEN,  64'd2,                  1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h01,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h01,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'hFF,                 1'b1, 1'b1, 16'd1},
      // bytes after the hit are consumed silently
      '{ROW_BYTE, CFG_PAT_LOW,  64'h01,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h01,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b1, 1'b0, 16'd0},
      // string shorter than the pattern
      '{ROW_BYTE, CFG_PAT_LOW,  64'hFF,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b1, 1'b0, 16'd0},
      // pattern 41 00: the zero byte can never be in the window
      '{ROW_CFG,  CFG_PAT_LOW,  64'h41,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h41,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h41,                 1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b1, 1'b0, 16'd0},
      // single-byte pattern
      '{ROW_CFG,  CFG_PAT_LEN,  64'd1,                  1'b0, 1'b0, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h41,                 1'b1, 1'b1, 16'd0},
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b0, 1'b0, 16'd0},
      // empty string, pattern not empty
      '{ROW_BYTE, CFG_PAT_LOW,  64'h00,                 1'b1, 1'b0, 16'd0}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        push_byte(directed_rows[i].val[7:0], directed_rows[i].typed,
                  directed_rows[i].t_found, directed_rows[i].t_off);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) run_phase(p);

    settle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sps_pkg.sv
rtl/sps_in_reg.sv
rtl/sps_matcher.sv
rtl/sps_out_reg.sv
rtl/short_pattern_substring_search_core.sv
sim/tb.sv
